// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the ring buffer block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/rbo_pkg.sv -----
// ----------------------------------------------------------------------------
// rbo_pkg
// Constants and types shared by the ring buffer modules.
// ----------------------------------------------------------------------------
package rbo_pkg;

    localparam int DEPTH          = 256;
    localparam int ADDR_BITS      = $clog2(DEPTH);
    localparam int DATA_BITS      = 16;
    localparam int CAP_BITS       = ADDR_BITS + 1;
    localparam int POS_BITS       = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = CAP_BITS;

    localparam logic [CAP_BITS-1:0] CAP_MAX = CAP_BITS'(DEPTH);
    localparam logic [CAP_BITS-1:0] CAP_MIN = CAP_BITS'(1);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic MODE_OVERWRITE = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_CAPACITY = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE     = CFG_INDEX_BITS'(1);

    typedef struct packed {
        logic accept;
        logic load_out;
    } rbo_cmd_t;

    typedef struct packed {
        logic out_free;
    } rbo_status_t;

endpackage

// ----- rtl/core/rbo_ram.sv -----
// ----------------------------------------------------------------------------
// rbo_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/rbo_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbo_ctrl
// Sequencer: takes one word, waits for the read data and a free output register, then loads the result.
// ----------------------------------------------------------------------------
module rbo_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rbo_pkg::rbo_status_t status,
    output rbo_pkg::rbo_cmd_t    cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOAD = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/rbo_dp.sv -----
// ----------------------------------------------------------------------------
// rbo_dp
// Datapath: configuration, ring pointers, entry store and result register.
// ----------------------------------------------------------------------------
module rbo_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [rbo_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [rbo_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  rbo_pkg::rbo_cmd_t                    cmd,
    output rbo_pkg::rbo_status_t                 status,
    input  logic                                 cmd_in,
    input  logic [rbo_pkg::DATA_BITS-1:0]        push_value,
    input  logic [rbo_pkg::POS_BITS-1:0]         position,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [rbo_pkg::DATA_BITS-1:0]        read_value,
    output logic [rbo_pkg::CAP_BITS-1:0]         fill_count,
    output logic                                 dropped,
    output logic                                 position_error
);

    logic [rbo_pkg::CAP_BITS-1:0]  capacity_reg, capacity_next;
    logic                          circular_reg, circular_next;
    logic [rbo_pkg::ADDR_BITS-1:0] oldest_reg, oldest_next;
    logic [rbo_pkg::CAP_BITS-1:0]  count_reg, count_next;
    logic [rbo_pkg::DEPTH-1:0]     valid_reg, valid_next;

    logic                          pend_read_reg;
    logic                          pend_hit_reg;
    logic [rbo_pkg::CAP_BITS-1:0]  pend_fill_reg;
    logic                          pend_dropped_reg;
    logic                          pend_perr_reg;

    logic                          out_valid_reg, out_valid_next;
    logic [rbo_pkg::DATA_BITS-1:0] read_value_reg;
    logic [rbo_pkg::CAP_BITS-1:0]  fill_count_reg;
    logic                          dropped_reg;
    logic                          position_error_reg;

    logic                          cfg_hit;
    logic [rbo_pkg::CAP_BITS-1:0]  cap_clamped;
    logic [rbo_pkg::CAP_BITS-1:0]  push_sum, push_wrap;
    logic [rbo_pkg::CAP_BITS-1:0]  read_sum, read_wrap;
    logic [rbo_pkg::CAP_BITS-1:0]  oldest_inc;
    logic [rbo_pkg::ADDR_BITS-1:0] push_slot, read_slot;
    logic                          is_full;
    logic                          pos_err;
    logic                          do_push, do_read, do_write, do_drop;
    logic [rbo_pkg::DATA_BITS-1:0] ram_rdata;

    assign cfg_hit = cfg_write_en
                     && ((cfg_index == rbo_pkg::CFG_CAPACITY) || (cfg_index == rbo_pkg::CFG_MODE));

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cap_clamped = rbo_pkg::CAP_MIN;
        end
        else if (cfg_data > rbo_pkg::CAP_MAX)
        begin
            cap_clamped = rbo_pkg::CAP_MAX;
        end
        else
        begin
            cap_clamped = cfg_data;
        end
    end

    // Wrap at capacity by one conditional subtract
    assign push_sum  = {1'b0, oldest_reg} + count_reg;
    assign push_wrap = (push_sum >= capacity_reg) ? (push_sum - capacity_reg) : push_sum;
    assign push_slot = push_wrap[rbo_pkg::ADDR_BITS-1:0];

    assign read_sum  = {1'b0, oldest_reg} + {1'b0, position};
    assign read_wrap = (read_sum >= capacity_reg) ? (read_sum - capacity_reg) : read_sum;
    assign read_slot = read_wrap[rbo_pkg::ADDR_BITS-1:0];

    assign oldest_inc = {1'b0, oldest_reg} + rbo_pkg::CAP_BITS'(1);

    assign is_full  = (count_reg == capacity_reg);
    assign pos_err  = ({1'b0, position} >= capacity_reg);
    assign do_push  = cmd.accept && (cmd_in == rbo_pkg::CMD_PUSH);
    assign do_read  = cmd.accept && (cmd_in == rbo_pkg::CMD_READ) && !pos_err;
    assign do_drop  = do_push && is_full && (circular_reg != rbo_pkg::MODE_OVERWRITE);
    assign do_write = do_push && !do_drop;

    always_comb
    begin
        capacity_next = capacity_reg;
        circular_next = circular_reg;
        oldest_next   = oldest_reg;
        count_next    = count_reg;
        valid_next    = valid_reg;
        if (cfg_hit)
        begin
            if (cfg_index == rbo_pkg::CFG_CAPACITY)
            begin
                capacity_next = cap_clamped;
            end
            else
            begin
                circular_next = cfg_data[0];
            end
            oldest_next = '0;
            count_next  = '0;
            valid_next  = '0;
        end
        else if (do_write)
        begin
            valid_next[push_slot] = 1'b1;
            if (!is_full)
            begin
                count_next = count_reg + rbo_pkg::CAP_BITS'(1);
            end
            else if (oldest_inc >= capacity_reg)
            begin
                oldest_next = '0;
            end
            else
            begin
                oldest_next = oldest_inc[rbo_pkg::ADDR_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= rbo_pkg::CAP_MAX;
            circular_reg <= rbo_pkg::MODE_OVERWRITE;
            oldest_reg   <= '0;
            count_reg    <= '0;
            valid_reg    <= '0;
        end
        else
        begin
            capacity_reg <= capacity_next;
            circular_reg <= circular_next;
            oldest_reg   <= oldest_next;
            count_reg    <= count_next;
            valid_reg    <= valid_next;
        end
    end

    rbo_ram #(
        .WIDTH (rbo_pkg::DATA_BITS),
        .DEPTH (rbo_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (do_write),
        .waddr (push_slot),
        .wdata (push_value),
        .re    (do_read),
        .raddr (read_slot),
        .rdata (ram_rdata)
    );

    // Hold the item's flags until the read data lands
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pend_read_reg    <= do_read;
            pend_hit_reg     <= valid_reg[read_slot];
            pend_fill_reg    <= count_next;
            pend_dropped_reg <= do_drop;
            pend_perr_reg    <= (cmd_in == rbo_pkg::CMD_READ) && pos_err;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            read_value_reg     <= (pend_read_reg && pend_hit_reg) ? ram_rdata : '0;
            fill_count_reg     <= pend_fill_reg;
            dropped_reg        <= pend_dropped_reg;
            position_error_reg <= pend_perr_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_value     = read_value_reg;
    assign fill_count     = fill_count_reg;
    assign dropped        = dropped_reg;
    assign position_error = position_error_reg;

endmodule

// ----- rtl/core/ring_buffer_with_overwrite_mode_top.sv -----
// After a word is accepted, the S_LOAD state loads its result into the output register once that register is free.
// A new word is taken only after the last result is loaded, as S_LOAD waits out the entry RAM's registered read.
// A result may wait in the output register while the next word is taken.
// Reset clears pointers, fill count and 256 entry valid flags at once; no sweep.
// A configuration write to the capacity or mode index clears the same state.
// ----------------------------------------------------------------------------
// ring_buffer_with_overwrite_mode_top
// Ring buffer with bounded or overwrite-oldest push and offset reads.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ring_buffer_with_overwrite_mode_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [rbo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rbo_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               cmd,
    input  logic [rbo_pkg::DATA_BITS-1:0]      push_value,
    input  logic [rbo_pkg::POS_BITS-1:0]       position,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rbo_pkg::DATA_BITS-1:0]      read_value,
    output logic [rbo_pkg::CAP_BITS-1:0]       fill_count,
    output logic                               dropped,
    output logic                               position_error
);

    rbo_pkg::rbo_cmd_t    ctrl_cmd;
    rbo_pkg::rbo_status_t dp_status;

    rbo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    rbo_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (ctrl_cmd),
        .status         (dp_status),
        .cmd_in         (cmd),
        .push_value     (push_value),
        .position       (position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_value     (read_value),
        .fill_count     (fill_count),
        .dropped        (dropped),
        .position_error (position_error)
    );

    `ASSERT_NEXT(a_one_word_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
    `ASSERT_NEXT(a_result_follows_word, clk, rst_n, !in_ready && !out_valid, out_valid)
    `ASSERT_SAME(a_flags_exclusive, clk, rst_n, out_valid, !(dropped && position_error))
    `ASSERT_SAME(a_zero_without_read, clk, rst_n, out_valid && (dropped || position_error), read_value == '0)
    `ASSERT_SAME(a_fill_in_range, clk, rst_n, out_valid, fill_count <= rbo_pkg::CAP_MAX)

endmodule

// ----- tb/tb_ring_buffer_with_overwrite_mode_top.sv -----
// ----------------------------------------------------------------------------
// tb_ring_buffer_with_overwrite_mode_top
// Self-checking bench for the ring buffer with bounded and overwrite modes.
// A queue-fed driver sends push and read words, and a clocked predictor
// computes each expected result as the word is accepted. A monitor checks
// every result field. Phases cover several capacity and mode settings, and
// vary the idle and stall rates on both channels.
// ----------------------------------------------------------------------------
module tb_ring_buffer_with_overwrite_mode_top;

    import rbo_pkg::*;

    localparam logic                      MODE_BOUNDED   = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_A    = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_B    = CFG_INDEX_BITS'(3);
    localparam int                        STALL_LIMIT    = 4000;
    localparam int                        REPORT_LIMIT   = 10;

    typedef struct packed {
        logic                 cmd;
        logic [DATA_BITS-1:0] push_value;
        logic [POS_BITS-1:0]  position;
    } in_word_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] read_value;
        logic [CAP_BITS-1:0]  fill_count;
        logic                 dropped;
        logic                 position_error;
    } out_word_t;

    logic                       clk;
    logic                       rst_n          = 1'b0;
    logic                       cfg_write_en   = 1'b0;
    logic [CFG_INDEX_BITS-1:0]  cfg_index      = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_data       = '0;
    logic                       in_valid       = 1'b0;
    logic                       in_ready;
    logic                       cmd            = CMD_PUSH;
    logic [DATA_BITS-1:0]       push_value     = '0;
    logic [POS_BITS-1:0]        position       = '0;
    logic                       out_valid;
    logic                       out_ready      = 1'b0;
    logic [DATA_BITS-1:0]       read_value;
    logic [CAP_BITS-1:0]        fill_count;
    logic                       dropped;
    logic                       position_error;

    ring_buffer_with_overwrite_mode_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .push_value     (push_value),
        .position       (position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_value     (read_value),
        .fill_count     (fill_count),
        .dropped        (dropped),
        .position_error (position_error)
    );

    // Predicted ring state
    logic [DATA_BITS-1:0] ring_store [DEPTH];
    int                   ring_cap;
    logic                 ring_mode;
    int                   ring_oldest;
    int                   ring_count;

    in_word_t  pending_words[$];
    out_word_t predicted_results[$];

    int  send_idle_pct;
    int  recv_stall_pct;
    logic in_taken;
    int  mismatches;
    int  stall_cycles;
    int  n_push, n_read, n_drop, n_overwrite, n_pos_err, n_reg_writes;

    function automatic void ring_clear();
        for (int i = 0; i < DEPTH; i++)
        begin
            ring_store[i] = '0;
        end
        ring_oldest = 0;
        ring_count  = 0;
    endfunction

    function automatic void ring_apply_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                           logic [CFG_DATA_BITS-1:0] data);
        if (idx == CFG_CAPACITY)
        begin
            if (data == '0)
                ring_cap = 1;
            else if (int'(data) > DEPTH)
                ring_cap = DEPTH;
            else
                ring_cap = int'(data);
            ring_clear();
        end
        else if (idx == CFG_MODE)
        begin
            ring_mode = data[0];
            ring_clear();
        end
    endfunction

    function automatic out_word_t ring_apply_word(in_word_t w);
        out_word_t r;
        int        slot;
        r = '0;
        if (w.cmd == CMD_PUSH)
        begin
            n_push++;
            slot = ring_oldest + ring_count;
            if (slot >= ring_cap)
                slot -= ring_cap;
            if (ring_count < ring_cap)
            begin
                ring_store[slot] = w.push_value;
                ring_count++;
            end
            else if (ring_mode == MODE_OVERWRITE)
            begin
                ring_store[slot] = w.push_value;
                ring_oldest++;
                if (ring_oldest >= ring_cap)
                    ring_oldest -= ring_cap;
                n_overwrite++;
            end
            else
            begin
                r.dropped = 1'b1;
                n_drop++;
            end
        end
        else
        begin
            n_read++;
            if (int'(w.position) >= ring_cap)
            begin
                r.position_error = 1'b1;
                n_pos_err++;
            end
            else
            begin
                slot = ring_oldest + int'(w.position);
                if (slot >= ring_cap)
                    slot -= ring_cap;
                r.read_value = ring_store[slot];
            end
        end
        r.fill_count = CAP_BITS'(ring_count);
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Driver: hold a word until accepted, then advance or idle
    always @(negedge clk)
    begin : drive_words
        in_word_t w;
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                w          = pending_words.pop_front();
                cmd        <= w.cmd;
                push_value <= w.push_value;
                position   <= w.position;
                in_valid   <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        in_taken = 1'b0;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: check results first, then predict for the accepted word
    always @(posedge clk)
    begin : check_results
        out_word_t got;
        out_word_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{read_value, fill_count, dropped, position_error};
                if (predicted_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: value %h fill %0d drop %b perr %b",
                                 got.read_value, got.fill_count, got.dropped,
                                 got.position_error);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("mismatch: exp value %h fill %0d drop %b perr %b, %s",
                                     want.read_value, want.fill_count, want.dropped,
                                     want.position_error,
                                     $sformatf("got value %h fill %0d drop %b perr %b",
                                               got.read_value, got.fill_count,
                                               got.dropped, got.position_error));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                predicted_results.push_back(
                    ring_apply_word('{cmd, push_value, position}));
                in_taken = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_word(logic c, logic [DATA_BITS-1:0] v, logic [POS_BITS-1:0] p);
        pending_words.push_back('{c, v, p});
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending_words.size() != 0 || in_valid || predicted_results.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        drain();
        cfg_index    <= idx;
        cfg_data     <= data;
        cfg_write_en <= 1'b1;
        ring_apply_reg(idx, data);
        n_reg_writes++;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic set_idle(int mode);
        case (mode % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
        endcase
    endtask

    initial
    begin
        int         n_words;
        int         push_pct;
        int         pick;
        int         cap_val;
        logic       mode_val;
        in_word_t   w;

        mismatches   = 0;
        stall_cycles = 0;
        in_taken     = 1'b0;
        n_push = 0; n_read = 0; n_drop = 0; n_overwrite = 0; n_pos_err = 0;
        n_reg_writes = 0;
        ring_cap  = DEPTH;
        ring_mode = MODE_OVERWRITE;
        ring_clear();
        set_idle(0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty store at reset size, field extremes, read past fill
        send_word(CMD_READ, '0, '0);
        send_word(CMD_READ, '1, '1);
        send_word(CMD_PUSH, '0, '1);
        send_word(CMD_PUSH, '1, '0);
        send_word(CMD_PUSH, 16'h5555, 8'hAA);
        send_word(CMD_READ, '0, 8'd0);
        send_word(CMD_READ, '0, 8'd1);
        send_word(CMD_READ, '0, 8'd2);
        send_word(CMD_READ, '0, 8'd3);

        // Capacity zero taken as one, bounded: drop when full
        write_reg(CFG_CAPACITY, '0);
        write_reg(CFG_MODE, {CFG_DATA_BITS{1'b1}} ^ CFG_DATA_BITS'(1));
        send_word(CMD_PUSH, 16'h1234, '0);
        send_word(CMD_PUSH, 16'hFEDC, '0);
        send_word(CMD_READ, '0, 8'd0);
        send_word(CMD_READ, '0, 8'd1);

        // Small circular ring: overwrite oldest and wrap
        write_reg(CFG_MODE, CFG_DATA_BITS'(MODE_OVERWRITE));
        write_reg(CFG_CAPACITY, CFG_DATA_BITS'(3));
        send_word(CMD_PUSH, 16'h0001, '0);
        send_word(CMD_PUSH, 16'h0002, '0);
        send_word(CMD_PUSH, 16'h0003, '0);
        send_word(CMD_PUSH, 16'h0004, '0);
        send_word(CMD_READ, '0, 8'd0);
        send_word(CMD_READ, '0, 8'd2);
        send_word(CMD_READ, '0, 8'd3);

        // Writes to unused indexes leave the store alone
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, '0);
        send_word(CMD_READ, '0, 8'd1);

        // Capacity above depth clamps to depth
        write_reg(CFG_CAPACITY, '1);
        send_word(CMD_PUSH, 16'hBEEF, '0);
        send_word(CMD_READ, '0, 8'd255);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       cap_val = DEPTH;
                1:       cap_val = 1;
                2:       cap_val = $urandom_range(20, 2);
                3:       cap_val = 0;
                4:       cap_val = $urandom_range(511, DEPTH + 1);
                default: cap_val = $urandom_range(120, 21);
            endcase
            if (ph == 0)
                mode_val = MODE_OVERWRITE;
            else if (ph == 4)
                mode_val = MODE_BOUNDED;
            else
                mode_val = 1'($urandom_range(1));
            write_reg(CFG_CAPACITY, CFG_DATA_BITS'(cap_val));
            write_reg(CFG_MODE, {(CFG_DATA_BITS-1)'($urandom_range(255)), mode_val});
            set_idle(ph);

            push_pct = (ring_cap >= 64) ? 85 : 60;
            n_words  = (ring_cap >= 64) ? ring_cap * 5 / 4 : 90;
            for (int i = 0; i < n_words; i++)
            begin
                w.cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_READ;
                case ($urandom_range(7))
                    0:       w.push_value = '0;
                    1:       w.push_value = '1;
                    default: w.push_value = DATA_BITS'($urandom);
                endcase
                pick = $urandom_range(9);
                if (pick < 7)
                    w.position = POS_BITS'($urandom_range(ring_cap - 1));
                else if (pick == 7)
                    w.position = POS_BITS'((ring_cap < DEPTH) ? ring_cap : DEPTH - 1);
                else
                    w.position = POS_BITS'($urandom_range(255));
                pending_words.push_back(w);
                // hold the sender until every result is back
                if (i == n_words / 2)
                    drain();
            end
        end

        drain();
        repeat (5) @(posedge clk);

        $display("covered %0d pushes, %0d reads, %0d register writes",
                 n_push, n_read, n_reg_writes);
        $display("  %0d dropped, %0d overwrites, %0d position errors, %0d mismatches",
                 n_drop, n_overwrite, n_pos_err, mismatches);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
